### sv/nq_pkg.sv
// Shared constants and the result record for the N-queens search block.
package nq_pkg;

	// Largest board the search supports
	localparam int MAX_SIZE = 16;
	// Index of one row or column of the board
	localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	// Counts that must also hold the board size itself
	localparam int CNT_W    = $clog2(MAX_SIZE + 1);
	// Fixed widths of the beat fields
	localparam int SIZE_W   = 5;
	localparam int FIELD_W  = 4;

	// One result beat, before packing onto the stream
	typedef struct packed {
		logic [FIELD_W-1:0] row_index;
		logic [FIELD_W-1:0] queen_column;
		logic               found;
		logic               last;
	} nq_res_t;

endpackage

### sv/nq_check.sv
// Shared attack check: does one placed queen hit the trial square.
module nq_check
	import nq_pkg::*;
(
	input  logic [IDX_W-1:0] placed_col,
	input  logic [CNT_W-1:0] trial_col,
	input  logic [CNT_W-1:0] row_gap,
	output logic             conflict
);

	localparam int SUM_W = CNT_W + 1;

	logic [SUM_W-1:0] p_ext;
	logic [SUM_W-1:0] t_ext;
	logic [SUM_W-1:0] d_ext;

	assign p_ext = SUM_W'(placed_col);
	assign t_ext = SUM_W'(trial_col);
	assign d_ext = SUM_W'(row_gap);

	// same column, or either upper diagonal
	assign conflict = (p_ext == t_ext) || (p_ext + d_ext == t_ext) || (t_ext + d_ext == p_ext);

endmodule

### sv/nq_search.sv
// Backtracking sequencer with the placed-column store and result issue.
module nq_search
	import nq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SIZE_W-1:0] board_size,
	output logic              res_valid,
	input  logic              res_ready,
	output nq_res_t           res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TRY,
		S_SCAN,
		S_BACK,
		S_EMIT_RD,
		S_EMIT_OUT,
		S_MISS
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] row_q;
	logic [CNT_W-1:0] col_q;
	logic [IDX_W-1:0] scan_q;
	logic [IDX_W-1:0] emit_q;

	// placed column of each row, no reset: only read after written
	logic [IDX_W-1:0] mem_q [MAX_SIZE];
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;

	logic             solved;
	logic             col_exhausted;
	logic             scan_done;
	logic             emit_done;
	logic             conflict;
	logic             size_bad;
	logic [CNT_W-1:0] row_gap;
	logic [CNT_W-1:0] row_dec;

	assign solved        = (row_q == n_q);
	assign col_exhausted = (col_q >= n_q);
	assign row_gap       = row_q - CNT_W'(scan_q);
	assign row_dec       = row_q - CNT_W'(1);
	assign scan_done     = (CNT_W'(scan_q) + CNT_W'(1) == row_q);
	assign emit_done     = (CNT_W'(emit_q) + CNT_W'(1) == n_q);
	assign size_bad      = (board_size == '0) || (int'(board_size) > MAX_SIZE);

	// single compare unit, one earlier row per cycle
	nq_check u_check (
		.placed_col (rd_q),
		.trial_col  (col_q),
		.row_gap    (row_gap),
		.conflict   (conflict)
	);

	// store write: a safe square is committed for the current row
	assign wr_en = ((state_q == S_TRY) && !solved && !col_exhausted && (row_q == '0)) ||
	               ((state_q == S_SCAN) && !conflict && scan_done);

	// store read address
	always_comb begin
		case (state_q)
			S_TRY:   rd_addr = col_exhausted ? row_dec[IDX_W-1:0] : '0;
			S_SCAN:  rd_addr = scan_q + IDX_W'(1);
			default: rd_addr = emit_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[row_q[IDX_W-1:0]] <= col_q[IDX_W-1:0];
		end
		rd_q <= mem_q[rd_addr];
	end

	// search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			row_q   <= '0;
			col_q   <= '0;
			scan_q  <= '0;
			emit_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						row_q <= '0;
						col_q <= '0;
						if (size_bad) begin
							state_q <= S_MISS;
						end else begin
							n_q     <= CNT_W'(board_size);
							state_q <= S_TRY;
						end
					end
				end
				S_TRY: begin
					if (solved) begin
						emit_q  <= '0;
						state_q <= S_EMIT_RD;
					end else if (col_exhausted) begin
						if (row_q == '0) begin
							state_q <= S_MISS;
						end else begin
							row_q   <= row_dec;
							state_q <= S_BACK;
						end
					end else if (row_q == '0) begin
						// nothing above the first row
						row_q <= row_q + CNT_W'(1);
						col_q <= '0;
					end else begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (conflict) begin
						col_q   <= col_q + CNT_W'(1);
						state_q <= S_TRY;
					end else if (scan_done) begin
						row_q   <= row_q + CNT_W'(1);
						col_q   <= '0;
						state_q <= S_TRY;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				S_BACK: begin
					// resume one column past the queen just lifted
					col_q   <= CNT_W'(rd_q) + CNT_W'(1);
					state_q <= S_TRY;
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (res_ready) begin
						if (emit_done) begin
							state_q <= S_IDLE;
						end else begin
							emit_q  <= emit_q + IDX_W'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_MISS: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT_OUT) || (state_q == S_MISS);

	// result fields; a miss reports row 0, column 0
	always_comb begin
		res.found        = (state_q == S_EMIT_OUT);
		res.row_index    = res.found ? FIELD_W'(emit_q) : '0;
		res.queen_column = res.found ? FIELD_W'(rd_q) : '0;
		res.last         = (state_q == S_MISS) || emit_done;
	end

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("input taken while a result is pending");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (CNT_W'(scan_q) < row_q))
		else $error("scan row beyond current row");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((col_q < n_q) && (row_q < n_q)))
		else $error("store write outside the board");

	a_miss_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.found) |-> (res.last && (res.row_index == '0) &&
		(res.queen_column == '0)))
		else $error("malformed not-found result");

	a_back_source: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BACK) |-> ($past(state_q) == S_TRY))
		else $error("backtrack entered from wrong state");

endmodule

### sv/n_queens_first_solution.sv
// Top level of the first-solution N-queens search with its output register.
//
// Input stream (s_axis_*): one beat carries a board size in tdata[4:0].
// A beat is taken only while the block is idle; tready stays low for the
// whole search and until the last result beat has left the search engine.
// Output stream (m_axis_*): one beat per row, row_index and queen_column in
// tdata, tuser high when a placement was found, tlast on the final beat.
// Sizes with no placement (2, 3, zero, above 16) give a single beat with
// tuser low, tlast high and zero data.
// Search time is data dependent: each tried square passes the try state
// and then the shared attack check, which compares the earlier rows in turn
// and stops at the first attack; a step back passes the try and back
// states, and each result beat is read from the column store and then issued.
// An output register decouples the receiver; while m_axis_tready is low the
// held beat stays and the search engine waits at its current result.
// Reset (arst_n low) returns the engine to idle and empties the output
// register; the column store needs no clearing.
module n_queens_first_solution
	import nq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [4:0] board_size
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [3:0] row_index, [7:4] queen_column
	output logic       m_axis_tuser,   // [0] found
	output logic       m_axis_tlast
);

	logic    res_valid;
	logic    res_ready;
	nq_res_t res;
	nq_res_t out_q;
	logic    out_valid_q;

	nq_search u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.board_size (s_axis_tdata[SIZE_W-1:0]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.queen_column, out_q.row_index};
	assign m_axis_tuser  = out_q.found;
	assign m_axis_tlast  = out_q.last;

endmodule

### verif/n_queens_first_solution_tb.sv
// Self-checking testbench for the first-solution N-queens search block.
module n_queens_first_solution_tb;
	import nq_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 9;
	localparam int NUM_DIRECTED = 20;
	localparam int RANDOM_ITEMS = 80;
	localparam int TOTAL_ITEMS  = NUM_DIRECTED + RANDOM_ITEMS;
	localparam int PHASE_LEN    = TOTAL_ITEMS / 3;
	localparam int CYCLE_LIMIT  = 20_000_000;
	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES  = 800;
	localparam int SHOW_LIMIT   = 10;

	// Predicts the placement for each board size and checks result beats
	class placement_board;
		nq_res_t expected_rows[$];
		int      column_of_row[MAX_SIZE];
		int      mismatches;
		int      beats_seen;
		int      solved;
		int      unsolvable;

		function void push_row(int r, int c, bit f, bit l);
			nq_res_t e;
			e.row_index    = r[FIELD_W-1:0];
			e.queen_column = c[FIELD_W-1:0];
			e.found        = f;
			e.last         = l;
			expected_rows.push_back(e);
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction

		// Depth-first search: rows in order, columns from 0 upward
		function void note_size(logic [SIZE_W-1:0] size);
			int n;
			int row;
			int col;
			bit ok;
			n = int'(size);
			if (n == 0 || n > MAX_SIZE) begin
				unsolvable++;
				push_row(0, 0, 1'b0, 1'b1);
				return;
			end
			row = 0;
			col = 0;
			while (row < n) begin
				if (col >= n) begin
					// row exhausted: step back, or give up at the top row
					if (row == 0) begin
						unsolvable++;
						push_row(0, 0, 1'b0, 1'b1);
						return;
					end
					row--;
					col = column_of_row[row] + 1;
				end else begin
					// same column or either upper diagonal is an attack
					ok = 1'b1;
					for (int k = 0; k < row && ok; k++) begin
						if (column_of_row[k] == col || column_of_row[k] + (row - k) == col ||
						    col + (row - k) == column_of_row[k])
							ok = 1'b0;
					end
					if (ok) begin
						column_of_row[row] = col & 15;
						row++;
						col = 0;
					end else begin
						col++;
					end
				end
			end
			solved++;
			for (int k = 0; k < n; k++)
				push_row(k, column_of_row[k], 1'b1, k == n - 1);
		endfunction

		function void check_beat(nq_res_t got);
			nq_res_t want;
			beats_seen++;
			if (expected_rows.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display("unexpected beat: row %0d col %0d found %0b last %0b",
						got.row_index, got.queen_column, got.found, got.last);
				return;
			end
			want = expected_rows.pop_front();
			if (got.row_index !== want.row_index || got.queen_column !== want.queen_column ||
			    got.found !== want.found || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= SHOW_LIMIT)
					$display({"beat mismatch: exp row %0d col %0d found %0b last %0b,",
						" got row %0d col %0d found %0b last %0b"},
						want.row_index, want.queen_column, want.found, want.last,
						got.row_index, got.queen_column, got.found, got.last);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [4:0] board_size
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [3:0] row_index, [7:4] queen_column
	logic       m_axis_tuser;   // [0] found
	logic       m_axis_tlast;

	placement_board board;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_armed;
	int  hold_left;
	int  cycles;
	int  input_stalls;

	// Every legal size: 1 to 8 (both unsolvable ones), out-of-range sizes, then 16 and 9 to 15
	int directed_sizes [NUM_DIRECTED] = '{1, 2, 3, 4, 5, 6, 7, 8, 0, 17, 31, 24, 16,
	                                      9, 10, 11, 12, 13, 14, 15};

	n_queens_first_solution u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Cycle count, run limit and input back-pressure tally
	always @(posedge clk) begin
		cycles++;
		if (arst_n && s_axis_tvalid && !s_axis_tready)
			input_stalls++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// Result beat monitor
	always @(posedge clk) begin
		nq_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tuser, m_axis_tlast};
			board.check_beat(got);
		end
	end

	// Receiver: random stalls, plus one long hold-off when armed
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed) begin
				hold_armed = 1'b0;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_size(input logic [SIZE_W-1:0] size);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, size};
		do @(posedge clk); while (!s_axis_tready);
		board.note_size(size);
	endtask

	// Pause the sender until every expected beat has arrived
	task automatic wait_drained();
		do @(posedge clk); while (board.pending() != 0);
	endtask

	initial begin
		int roll;
		logic [SIZE_W-1:0] size;

		board          = new();
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		send_idle_pct  = 6;
		recv_idle_pct  = 46;
		hold_armed     = 1'b0;
		hold_left      = 0;
		cycles         = 0;
		input_stalls   = 0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < TOTAL_ITEMS; i++) begin
			// phase changes: sender goes quiet first
			if (i == PHASE_LEN || i == 2 * PHASE_LEN) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				wait_drained();
				if (i == PHASE_LEN) begin
					send_idle_pct = 46;
					recv_idle_pct = 6;
				end else begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_armed    = 1'b1;
				end
			end
			if (i < NUM_DIRECTED) begin
				size = SIZE_W'(directed_sizes[i]);
			end else begin
				// mostly cheap legal sizes, some out of range, the odd larger one
				roll = $urandom_range(99);
				if (roll < 6)
					size = '0;
				else if (roll < 14)
					size = SIZE_W'($urandom_range(31, MAX_SIZE + 1));
				else if (roll < 17)
					size = SIZE_W'(13);
				else
					size = SIZE_W'($urandom_range(12, 1));
			end
			send_size(size);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("searched %0d board sizes: %0d placed, %0d with no placement; %0d beats",
			board.solved + board.unsolvable, board.solved, board.unsolvable,
			board.beats_seen);
		$display("input held off for %0d cycles, incl. one long output stall; %0d mismatches",
			input_stalls, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
sv/nq_pkg.sv
sv/nq_check.sv
sv/nq_search.sv
sv/n_queens_first_solution.sv
verif/n_queens_first_solution_tb.sv
